[src/midi_byte_stream_parser_unit_defines.svh]
// assertion macros for the midi byte stream parser
`ifndef MIDI_BYTE_STREAM_PARSER_UNIT_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define MBSP_ASSERT_NOW(name, clk, rst_n, a, c) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("mbsp check failed");

// next-cycle implication
`define MBSP_ASSERT_NEXT(name, clk, rst_n, a, c) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("mbsp check failed");

`endif

[src/mbsp_pkg.sv]
package mbsp_pkg;

	localparam logic [1:0] KIND_CHANNEL = 2'd0;
	localparam logic [1:0] KIND_SYSTEM  = 2'd1;
	localparam logic [1:0] KIND_SYSEX   = 2'd2;

	localparam logic [3:0] NIB_SYSTEM   = 4'hF;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_PRESSURE = 4'hD;
	localparam logic [7:0] SYSEX_BEGIN  = 8'hF0;
	localparam logic [7:0] SYSEX_END    = 8'hF7;

	typedef struct packed {
		logic [1:0] msg_kind;
		logic [7:0] status_byte;
		logic [7:0] first_param;
		logic [7:0] second_param;
	} msg_t;

endpackage

[src/midi_byte_stream_parser_unit.sv]
// channel  dir  tdata (low bit up)                         tuser
// s_*      in   rx_byte[7:0]                               -
// m_*      out  status_byte, first_param, second_param     msg_kind[1:0]
//
// One byte per cycle while s_tready is high; a result is registered in the output register, or in the skid stage.
// Parser state is held in flops and updated in the cycle a beat is taken.
// A two-entry output register and skid stage drop s_tready only when both are full.
// Reset clears all parser state and empties the output stage.
module midi_byte_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // status_byte, first_param, second_param
	output logic [1:0]  m_tuser   // msg_kind
);
	import mbsp_pkg::*;

	logic accept;
	logic res_valid;
	msg_t res;
	msg_t out_msg;

	assign accept = s_tvalid && s_tready;

	mbsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (s_tdata),
		.res_valid (res_valid),
		.res       (res)
	);

	mbsp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_msg  (res),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_msg   (out_msg)
	);

	assign m_tdata = {out_msg.second_param, out_msg.first_param, out_msg.status_byte};
	assign m_tuser = out_msg.msg_kind;

endmodule

[src/mbsp_core.sv]
module mbsp_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	output logic          res_valid,
	output mbsp_pkg::msg_t res
);
	import mbsp_pkg::*;

	logic       in_sysex_q;
	logic [7:0] running_status_q;
	logic [1:0] params_expected_q;
	logic       param_position_q;
	logic [7:0] held_first_q;
	logic [7:0] held_second_q;

	logic       is_sys;
	logic       is_status;
	logic       is_sx_edge;
	logic       have_status;
	logic       done;
	logic [1:0] next_pos;

	assign is_sys      = rx_byte[7:4] == NIB_SYSTEM;
	assign is_sx_edge  = (rx_byte == SYSEX_BEGIN) || (rx_byte == SYSEX_END);
	assign is_status   = rx_byte[7];
	assign have_status = running_status_q != 8'd0;
	assign next_pos    = {1'b0, param_position_q} + 2'd1;
	assign done        = next_pos >= params_expected_q;

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		priority if (is_sys) begin
			if (!is_sx_edge) begin
				res_valid       = 1'b1;
				res.msg_kind    = KIND_SYSTEM;
				res.first_param = rx_byte;
			end
		end else if (is_status) begin
			res_valid = 1'b0;
		end else if (in_sysex_q) begin
			res_valid       = 1'b1;
			res.msg_kind    = KIND_SYSEX;
			res.first_param = rx_byte;
		end else begin
			if (have_status) begin
				res_valid        = done;
				res.msg_kind     = KIND_CHANNEL;
				res.status_byte  = running_status_q;
				res.first_param  = param_position_q ? held_first_q : rx_byte;
				res.second_param = param_position_q ? rx_byte : held_second_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sysex_q        <= 1'b0;
			running_status_q  <= 8'd0;
			params_expected_q <= 2'd0;
			param_position_q  <= 1'b0;
			held_first_q      <= 8'd0;
			held_second_q     <= 8'd0;
		end else if (accept) begin
			priority if (is_sys) begin
				if (rx_byte == SYSEX_BEGIN) begin
					in_sysex_q <= 1'b1;
				end else if (rx_byte == SYSEX_END) begin
					in_sysex_q <= 1'b0;
				end else begin
					running_status_q <= 8'd0;
					held_first_q     <= rx_byte;
				end
			end else if (is_status) begin
				in_sysex_q        <= 1'b0;
				param_position_q  <= 1'b0;
				running_status_q  <= rx_byte;
				params_expected_q <= (rx_byte[7:4] == NIB_PROGRAM ||
					rx_byte[7:4] == NIB_PRESSURE) ? 2'd1 : 2'd2;
			end else if (in_sysex_q) begin
				running_status_q <= 8'd0;
				held_first_q     <= rx_byte;
			end else begin
				if (have_status) begin
					if (param_position_q) begin
						held_second_q <= rx_byte;
					end else begin
						held_first_q <= rx_byte;
					end
					param_position_q <= done ? 1'b0 : next_pos[0];
				end
			end
		end
	end

endmodule

[src/mbsp_skid.sv]
module mbsp_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbsp_pkg::msg_t push_msg,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output mbsp_pkg::msg_t out_msg
);
	import mbsp_pkg::*;

	logic main_valid_q;
	logic skid_valid_q;
	msg_t main_q;
	msg_t skid_q;
	logic pop;

	assign room      = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_msg   = main_q;
	assign pop       = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_msg;
			end else begin
				main_q <= push_msg;
			end
		end
	end

endmodule

[src/mbsp_checker.sv]
`include "midi_byte_stream_parser_unit_defines.svh"

module mbsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import mbsp_pkg::*;

	`MBSP_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`MBSP_ASSERT_NOW(a_kind, clk, arst_n, m_tvalid,
		m_tuser == KIND_CHANNEL || m_tuser == KIND_SYSTEM || m_tuser == KIND_SYSEX)
	`MBSP_ASSERT_NOW(a_raw_zero, clk, arst_n, m_tvalid && m_tuser != KIND_CHANNEL,
		m_tdata[7:0] == 8'd0 && m_tdata[23:16] == 8'd0)
	`MBSP_ASSERT_NOW(a_full, clk, arst_n, !s_tready, m_tvalid)

endmodule

bind midi_byte_stream_parser_unit mbsp_checker u_mbsp_checker (.*);
